FILE: rtl/tpdp_pkg.sv
// Package for the thresholded pixel density profiler.
// Holds sizes, operation and result codes, and the types shared by the modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tpdp_pkg;

  // Store sizes.
  localparam int MaxColumns = 1024;
  localparam int MaxRows    = 1024;

  // Widths derived from the store sizes.
  localparam int ColW     = $clog2(MaxColumns + 1);  // column position, saturates at MaxColumns
  localparam int ColAddrW = $clog2(MaxColumns);      // column store address
  localparam int RowW     = $clog2(MaxRows);         // row index, saturates at MaxRows-1

  // Fixed field widths.
  localparam int OpW    = 3;
  localparam int PixW   = 8;
  localparam int SelW   = 10;
  localparam int KindW  = 2;
  localparam int PosW   = 10;
  localparam int CountW = 11;
  localparam int QuadW  = 21;
  localparam int SumW   = QuadW + 2;
  localparam int CfgW   = 11;
  localparam int CfgIdxW = 2;

  localparam int InDataW  = 24;
  localparam int OutDataW = 128;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [QuadW-1:0]  QuadMax  = '1;

  // Queue between the front and back parts.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Operation codes on the input channel.
  localparam logic [OpW-1:0] OpFrameStart = 3'd0;
  localparam logic [OpW-1:0] OpRowStart   = 3'd1;
  localparam logic [OpW-1:0] OpPixel      = 3'd2;
  localparam logic [OpW-1:0] OpFrameEnd   = 3'd3;
  localparam logic [OpW-1:0] OpColRead    = 3'd4;

  // Result kinds on the output channel.
  localparam logic [KindW-1:0] KindRow     = 2'd0;
  localparam logic [KindW-1:0] KindSummary = 2'd1;
  localparam logic [KindW-1:0] KindColumn  = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgIdxThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxCenterCol = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxCenterRow = 2'd2;

  localparam logic [PixW-1:0] ThresholdReset = 8'd15;
  localparam logic [CfgW-1:0] CenterReset    = 11'd512;

  // Work the back part carries out for one queued item.
  typedef enum logic [2:0] {
    ActFrameStart,
    ActRowStart,
    ActPixel,
    ActFrameEnd,
    ActColRead
  } act_e;

  typedef struct packed {
    act_e              act;
    logic              emit_row;  // an open row is closed by this item
    logic [ColW-1:0]   col;
    logic [RowW-1:0]   row;
    logic [PixW-1:0]   pix;
    logic [SelW-1:0]   sel;
  } item_t;

  typedef struct packed {
    logic [PixW-1:0] threshold;
    logic [CfgW-1:0] center_col;
    logic [CfgW-1:0] center_row;
  } cfg_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [PosW-1:0]   pos;
    logic [CountW-1:0] count;
    logic [QuadW-1:0]  top_left;
    logic [QuadW-1:0]  top_right;
    logic [QuadW-1:0]  bottom_left;
    logic [QuadW-1:0]  bottom_right;
    logic [QuadW-1:0]  total;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/tpdp_front.sv
// Front part of the profiler: accepts input items and classifies them.
// Tracks row and column position and queues the work for the back part.
// Depends on tpdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpdp_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [tpdp_pkg::OpW-1:0]  op_i,
  input  wire logic [tpdp_pkg::PixW-1:0] pix_i,
  input  wire logic [tpdp_pkg::SelW-1:0] sel_i,
  input  wire logic                      q_full_i,
  output logic                           push_o,
  output tpdp_pkg::item_t                push_item_o
);

  logic                      row_open_q, row_open_d;
  logic [tpdp_pkg::ColW-1:0] col_q, col_d;
  logic [tpdp_pkg::RowW-1:0] row_q, row_d;
  logic                      accept;
  logic                      keep;
  logic [tpdp_pkg::RowW-1:0] row_next;
  logic [tpdp_pkg::ColW-1:0] col_next;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && keep;

  // Saturating position steps.
  assign row_next = (row_q == tpdp_pkg::RowW'(tpdp_pkg::MaxRows - 1)) ? row_q : row_q + 1'b1;
  assign col_next = (col_q == tpdp_pkg::ColW'(tpdp_pkg::MaxColumns)) ? col_q : col_q + 1'b1;

  // Classify the item and work out the position state it leaves behind.
  always_comb begin
    row_open_d            = row_open_q;
    col_d                 = col_q;
    row_d                 = row_q;
    keep                  = 1'b0;
    push_item_o.act       = tpdp_pkg::ActFrameStart;
    push_item_o.emit_row  = row_open_q;
    push_item_o.col       = col_q;
    push_item_o.row       = row_q;
    push_item_o.pix       = pix_i;
    push_item_o.sel       = sel_i;
    case (op_i)
      tpdp_pkg::OpFrameStart: begin
        keep            = 1'b1;
        push_item_o.act = tpdp_pkg::ActFrameStart;
        row_open_d      = 1'b0;
        col_d           = '0;
        row_d           = '0;
      end
      tpdp_pkg::OpRowStart: begin
        keep            = 1'b1;
        push_item_o.act = tpdp_pkg::ActRowStart;
        if (row_open_q) begin
          row_d = row_next;
        end
        row_open_d = 1'b1;
        col_d      = '0;
      end
      tpdp_pkg::OpPixel: begin
        // A pixel outside a row does nothing at all.
        keep            = row_open_q;
        push_item_o.act = tpdp_pkg::ActPixel;
        if (row_open_q) begin
          col_d = col_next;
        end
      end
      tpdp_pkg::OpFrameEnd: begin
        keep            = 1'b1;
        push_item_o.act = tpdp_pkg::ActFrameEnd;
        if (row_open_q) begin
          row_d = row_next;
        end
        row_open_d = 1'b0;
      end
      tpdp_pkg::OpColRead: begin
        keep            = 1'b1;
        push_item_o.act = tpdp_pkg::ActColRead;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Position state advances with every accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_open_q <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
    end else if (accept) begin
      row_open_q <= row_open_d;
      col_q      <= col_d;
      row_q      <= row_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tpdp_queue.sv
// Short item queue between the front and back parts of the profiler.
// First-in first-out, with the head item visible while not empty.
// Depends on tpdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpdp_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire tpdp_pkg::item_t push_item_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output tpdp_pkg::item_t      head_o
);

  tpdp_pkg::item_t            slots_q [tpdp_pkg::QDepth];
  logic [tpdp_pkg::QPtrW-1:0] wr_ptr_q;
  logic [tpdp_pkg::QPtrW-1:0] rd_ptr_q;
  logic [tpdp_pkg::QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == tpdp_pkg::QCntW'(tpdp_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  // Item storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tpdp_back.sv
// Back part of the profiler: column store, row and quadrant counters, results.
// Reads the column store as an item leaves the queue and updates it in the next cycle.
// Depends on tpdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpdp_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire tpdp_pkg::cfg_t             cfg_i,
  input  wire logic                       q_empty_i,
  input  wire tpdp_pkg::item_t            q_head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output tpdp_pkg::result_t               out_result_o
);

  // Column store; entries at or beyond the fill mark belong to an older frame.
  logic [tpdp_pkg::CountW-1:0]   mem_q [tpdp_pkg::MaxColumns];
  logic [tpdp_pkg::CountW-1:0]   mem_rdata_q;
  logic [tpdp_pkg::ColW-1:0]     fill_q, fill_d;

  logic                          mem_we;
  logic [tpdp_pkg::ColAddrW-1:0] mem_waddr;
  logic [tpdp_pkg::CountW-1:0]   mem_wdata;
  logic [tpdp_pkg::ColAddrW-1:0] mem_raddr;

  // Execute stage.
  logic                          b_valid_q;
  tpdp_pkg::item_t               b_item_q;
  logic                          b_hit_q;
  logic [tpdp_pkg::CountW-1:0]   b_fwd_q;
  logic                          phase_q, phase_d;

  logic [tpdp_pkg::CountW-1:0]   row_cnt_q, row_cnt_d;
  logic [tpdp_pkg::QuadW-1:0]    quad_q [4];
  logic [tpdp_pkg::QuadW-1:0]    quad_d [4];

  logic                          out_valid_q;
  tpdp_pkg::result_t             out_q;

  logic                          out_free;
  logic                          need_out;
  logic                          b_done;
  logic                          col_in_store;
  logic                          sel_in_store;
  logic                          counted;
  logic                          q_right;
  logic                          q_bottom;
  logic [1:0]                    q_idx;
  logic [tpdp_pkg::CountW-1:0]   base;
  logic [tpdp_pkg::CountW-1:0]   px_old;
  logic [tpdp_pkg::CountW-1:0]   rd_old;
  logic [tpdp_pkg::SumW-1:0]     quad_sum;
  logic [tpdp_pkg::QuadW-1:0]    quad_total;
  tpdp_pkg::result_t             res;

  assign out_free     = !out_valid_q || out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

  // Take the next item whenever the execute stage is empty or finishing.
  assign pop_o     = !q_empty_i && (!b_valid_q || b_done);
  assign mem_raddr = (q_head_i.act == tpdp_pkg::ActColRead) ?
                     tpdp_pkg::ColAddrW'(q_head_i.sel) :
                     q_head_i.col[tpdp_pkg::ColAddrW-1:0];

  // Store lookups and the quadrant of a pixel.
  assign col_in_store = b_item_q.col < tpdp_pkg::ColW'(tpdp_pkg::MaxColumns);
  assign sel_in_store = 32'(b_item_q.sel) < 32'(tpdp_pkg::MaxColumns);
  assign base         = b_hit_q ? b_fwd_q : mem_rdata_q;
  assign px_old       = (b_item_q.col < fill_q) ? base : '0;
  assign rd_old       = (sel_in_store && (32'(b_item_q.sel) < 32'(fill_q))) ? base : '0;
  assign counted      = b_item_q.pix > cfg_i.threshold;
  assign q_right      = 32'(b_item_q.col) >= 32'(cfg_i.center_col);
  assign q_bottom     = 32'(b_item_q.row) >= 32'(cfg_i.center_row);
  assign q_idx        = {q_bottom, q_right};

  // Frame summary total, saturated.
  assign quad_sum   = tpdp_pkg::SumW'(quad_q[0]) + tpdp_pkg::SumW'(quad_q[1]) +
                      tpdp_pkg::SumW'(quad_q[2]) + tpdp_pkg::SumW'(quad_q[3]);
  assign quad_total = (quad_sum > tpdp_pkg::SumW'(tpdp_pkg::QuadMax)) ?
                      tpdp_pkg::QuadMax : quad_sum[tpdp_pkg::QuadW-1:0];

  // Column store write for a pixel inside the store.
  assign mem_we    = b_valid_q && (b_item_q.act == tpdp_pkg::ActPixel) && col_in_store;
  assign mem_waddr = b_item_q.col[tpdp_pkg::ColAddrW-1:0];
  assign mem_wdata = (counted && (px_old != tpdp_pkg::CountMax)) ? px_old + 1'b1 : px_old;

  // Work out the result and the state that the current item leaves.
  always_comb begin
    need_out         = 1'b0;
    b_done           = 1'b0;
    phase_d          = phase_q;
    row_cnt_d        = row_cnt_q;
    fill_d           = fill_q;
    for (int i = 0; i < 4; i++) begin
      quad_d[i] = quad_q[i];
    end
    res              = '0;
    res.kind         = tpdp_pkg::KindRow;
    res.pos          = tpdp_pkg::PosW'(b_item_q.row);
    res.count        = row_cnt_q;
    res.last         = 1'b1;
    if (b_valid_q) begin
      case (b_item_q.act)
        tpdp_pkg::ActFrameStart: begin
          b_done    = 1'b1;
          row_cnt_d = '0;
          fill_d    = '0;
          for (int i = 0; i < 4; i++) begin
            quad_d[i] = '0;
          end
        end
        tpdp_pkg::ActRowStart: begin
          need_out  = b_item_q.emit_row;
          b_done    = !need_out || out_free;
          // The closing row keeps its count until its result is taken.
          if (b_done) begin
            row_cnt_d = '0;
          end
        end
        tpdp_pkg::ActPixel: begin
          b_done = 1'b1;
          if (counted) begin
            if (row_cnt_q != tpdp_pkg::CountMax) begin
              row_cnt_d = row_cnt_q + 1'b1;
            end
            for (int i = 0; i < 4; i++) begin
              if ((2'(i) == q_idx) && (quad_q[i] != tpdp_pkg::QuadMax)) begin
                quad_d[i] = quad_q[i] + 1'b1;
              end
            end
          end
          if (col_in_store && (b_item_q.col >= fill_q)) begin
            fill_d = b_item_q.col + 1'b1;
          end
        end
        tpdp_pkg::ActFrameEnd: begin
          need_out = 1'b1;
          if (b_item_q.emit_row && !phase_q) begin
            // Closing row first, summary on the next result.
            res.last = 1'b0;
            if (out_free) begin
              phase_d = 1'b1;
            end
          end else begin
            res.kind         = tpdp_pkg::KindSummary;
            res.pos          = '0;
            res.count        = '0;
            res.top_left     = quad_q[0];
            res.top_right    = quad_q[1];
            res.bottom_left  = quad_q[2];
            res.bottom_right = quad_q[3];
            res.total        = quad_total;
            b_done           = out_free;
            if (out_free) begin
              phase_d   = 1'b0;
              row_cnt_d = '0;
            end
          end
        end
        tpdp_pkg::ActColRead: begin
          need_out  = 1'b1;
          b_done    = out_free;
          res.kind  = tpdp_pkg::KindColumn;
          res.pos   = tpdp_pkg::PosW'(b_item_q.sel);
          res.count = rd_old;
        end
        default: begin
          b_done = 1'b1;
        end
      endcase
    end
  end

  // Column store, with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  // Execute stage payload, with a bypass for a write in the read cycle.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_item_q <= q_head_i;
      b_hit_q  <= mem_we && (mem_waddr == mem_raddr);
      b_fwd_q  <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (pop_o) begin
      b_valid_q <= 1'b1;
    end else if (b_done) begin
      b_valid_q <= 1'b0;
    end
  end

  // Frame counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= 1'b0;
      row_cnt_q <= '0;
      fill_q    <= '0;
      for (int i = 0; i < 4; i++) begin
        quad_q[i] <= '0;
      end
    end else begin
      phase_q   <= phase_d;
      row_cnt_q <= row_cnt_d;
      fill_q    <= fill_d;
      for (int i = 0; i < 4; i++) begin
        quad_q[i] <= quad_d[i];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (need_out && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (need_out && out_free) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/thresholded_pixel_density_profiler.sv
// Top level of the thresholded pixel density profiler.
// Holds the configuration registers and joins the front part, the queue and the back part.
// Depends on tpdp_pkg, tpdp_front, tpdp_queue and tpdp_back.
//
// Usage:
//   Input items arrive on the s_axis channel: the operation in s_axis_tuser, the pixel
//   value and column select in s_axis_tdata. Operations are frame start, row start,
//   pixel, frame end and column read. Results leave on the m_axis channel: the result
//   kind in m_axis_tuser, tlast on the final result of an item, and the position,
//   count, quadrant counts and total in m_axis_tdata.
//   The cfg channel writes the threshold, center column and center row; it is always
//   ready and is meant to be used while no item is in flight.
// Timing:
//   One item is taken per cycle while the queue has room. A result passes through
//   the queue, the execute stage and the output register. A frame end with an open
//   row gives two results and holds the back part for both. The column store is a
//   single-port-write memory read as an item leaves the queue and written in the
//   next cycle, so pixels run at one per cycle unless the back part is held.
// Reset and stalls:
//   Reset empties the pipeline and counters and restores the default configuration;
//   no clearing pass is needed. When the receiver stalls, a four-item queue keeps the
//   input side taking items until it fills, then s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module thresholded_pixel_density_profiler (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Input items.
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [tpdp_pkg::InDataW-1:0]      s_axis_tdata,   // pixel_value, column_select
  input  wire logic [tpdp_pkg::OpW-1:0]          s_axis_tuser,   // operation
  // Result items.
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // position, count, top_left_count, top_right_count, bottom_left_count,
  // bottom_right_count, frame_total
  output logic [tpdp_pkg::OutDataW-1:0]          m_axis_tdata,
  output logic [tpdp_pkg::KindW-1:0]             m_axis_tuser,   // result_kind
  output logic                                   m_axis_tlast,   // last_of_run
  // Configuration writes.
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [tpdp_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [tpdp_pkg::CfgW-1:0]         cfg_data_i
);

  tpdp_pkg::cfg_t    cfg_q;
  logic              q_push;
  tpdp_pkg::item_t   q_push_item;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  tpdp_pkg::item_t   q_head;
  tpdp_pkg::result_t res;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold  <= tpdp_pkg::ThresholdReset;
      cfg_q.center_col <= tpdp_pkg::CenterReset;
      cfg_q.center_row <= tpdp_pkg::CenterReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tpdp_pkg::CfgIdxThreshold: cfg_q.threshold  <= cfg_data_i[tpdp_pkg::PixW-1:0];
        tpdp_pkg::CfgIdxCenterCol: cfg_q.center_col <= cfg_data_i;
        tpdp_pkg::CfgIdxCenterRow: cfg_q.center_row <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  tpdp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .pix_i       (s_axis_tdata[7:0]),
    .sel_i       (s_axis_tdata[17:8]),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_item_o (q_push_item)
  );

  tpdp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  tpdp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_empty_i    (q_empty),
    .q_head_i     (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_result_o (res)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata = {2'b00, res.total, res.bottom_right, res.bottom_left,
                         res.top_right, res.top_left, res.count, res.pos};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

FILE: rtl/tpdp_checker.sv
// Port-level checks for the thresholded pixel density profiler.
// Bound to the top level; depends on tpdp_pkg for the result kind codes.
`timescale 1ns / 1ps
`default_nettype none

module tpdp_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [tpdp_pkg::OutDataW-1:0]     m_axis_tdata,
  input wire logic [tpdp_pkg::KindW-1:0]        m_axis_tuser,
  input wire logic                              m_axis_tlast
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A row result that is not last is the closing row of a frame, followed by the summary.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && (m_axis_tuser == tpdp_pkg::KindRow) && !m_axis_tlast
    |=> m_axis_tvalid && (m_axis_tuser == tpdp_pkg::KindSummary))
    else $error("closing row not followed by frame summary");

  // A summary always ends its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == tpdp_pkg::KindSummary) |-> m_axis_tlast)
    else $error("frame summary without last flag");

  // Only a summary carries quadrant counts, and its total covers each quadrant.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != tpdp_pkg::KindSummary) |-> (m_axis_tdata[125:21] == '0))
    else $error("quadrant fields set on a row or column result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == tpdp_pkg::KindSummary) |->
      (m_axis_tdata[125:105] >= m_axis_tdata[41:21]) &&
      (m_axis_tdata[125:105] >= m_axis_tdata[62:42]) &&
      (m_axis_tdata[125:105] >= m_axis_tdata[83:63]) &&
      (m_axis_tdata[125:105] >= m_axis_tdata[104:84]))
    else $error("frame total below a quadrant count");

endmodule

bind thresholded_pixel_density_profiler tpdp_checker u_checker (.*);

`default_nettype wire
